### rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GHS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define GHS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define GHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define GHS_ASSERT(label, prop, msg)
`define GHS_ASSERT_IMPLY(label, ante, cons, msg)
`define GHS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/ghs_pkg.sv
package ghs_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_MTIME   = 4'd1,
		PH_XFL     = 4'd2,
		PH_OS      = 4'd3,
		PH_XLEN    = 4'd4,
		PH_EXTRA   = 4'd5,
		PH_NAME    = 4'd6,
		PH_COMMENT = 4'd7,
		PH_HCRC    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_STARTED = 2'd0,
		ST_MORE    = 2'd1,
		ST_LAST    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	localparam logic [2:0] SEC_MTIME   = 3'd0;
	localparam logic [2:0] SEC_XFL     = 3'd1;
	localparam logic [2:0] SEC_OS      = 3'd2;
	localparam logic [2:0] SEC_XLEN    = 3'd3;
	localparam logic [2:0] SEC_EXTRA   = 3'd4;
	localparam logic [2:0] SEC_NAME    = 3'd5;
	localparam logic [2:0] SEC_COMMENT = 3'd6;
	localparam logic [2:0] SEC_HCRC    = 3'd7;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// option flag bits, flg shifted down by one
	localparam int OPT_HCRC    = 0;
	localparam int OPT_EXTRA   = 1;
	localparam int OPT_NAME    = 2;
	localparam int OPT_COMMENT = 3;

	localparam logic [15:0] MTIME_LEN = 16'd4;
	localparam logic [15:0] XLEN_LEN  = 16'd2;
	localparam logic [15:0] HCRC_LEN  = 16'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [2:0] section;
	} result_t;

endpackage

### rtl/core/ghs_byte_if.sv
interface ghs_byte_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

### rtl/core/ghs_tag_if.sv
interface ghs_tag_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] section;

	modport source (output valid, output status, output section, input ready);
	modport sink (input valid, input status, input section, output ready);
endinterface

### rtl/core/ghs_in_stage.sv
module ghs_in_stage
	import ghs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	ghs_byte_if.sink       hdr,
	input  logic           take,
	output logic           valid_s1,
	output item_t          item_s1
);

	logic load;

	assign hdr.ready = !valid_s1 || take;
	assign load      = hdr.valid && hdr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= '{kind: hdr.kind, value: hdr.value};
		end
	end

endmodule

### rtl/core/ghs_walker.sv
`include "assert_macros.svh"

module ghs_walker
	import ghs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  item_t          item,
	output logic           take,
	ghs_tag_if.source      res
);

	phase_t      phase_q, phase_n;
	logic [15:0] remaining_q, remaining_n;
	logic [3:0]  opt_q, opt_n;
	logic [7:0]  low_q, low_n;
	result_t     res_n, res_s2;
	logic        valid_s2;

	// next section after the extra field
	function automatic phase_t after_extra(input logic [3:0] opt);
		if (opt[OPT_NAME]) begin
			return PH_NAME;
		end else if (opt[OPT_COMMENT]) begin
			return PH_COMMENT;
		end else if (opt[OPT_HCRC]) begin
			return PH_HCRC;
		end else begin
			return PH_IDLE;
		end
	endfunction

	function automatic phase_t after_name(input logic [3:0] opt);
		if (opt[OPT_COMMENT]) begin
			return PH_COMMENT;
		end else if (opt[OPT_HCRC]) begin
			return PH_HCRC;
		end else begin
			return PH_IDLE;
		end
	endfunction

	function automatic logic [15:0] entry_count(input phase_t ph, input logic [15:0] rem);
		if (ph == PH_HCRC) begin
			return HCRC_LEN;
		end else if (ph == PH_IDLE) begin
			return 16'd0;
		end else begin
			return rem;
		end
	endfunction

	assign take = item_valid && (!valid_s2 || res.ready);

	always_comb begin
		phase_n     = phase_q;
		remaining_n = remaining_q;
		opt_n       = opt_q;
		low_n       = low_q;
		res_n       = '{status: ST_IGNORED, section: SEC_MTIME};
		if (item.kind == KIND_START) begin
			opt_n       = item.value[4:1];
			phase_n     = PH_MTIME;
			remaining_n = MTIME_LEN;
			low_n       = 8'd0;
			res_n       = '{status: ST_STARTED, section: SEC_MTIME};
		end else begin
			case (phase_q)
				PH_MTIME: begin
					res_n.section = SEC_MTIME;
					remaining_n   = remaining_q - 16'd1;
					if (remaining_n == 16'd0) begin
						phase_n = PH_XFL;
					end
				end
				PH_XFL: begin
					res_n.section = SEC_XFL;
					phase_n       = PH_OS;
				end
				PH_OS: begin
					res_n.section = SEC_OS;
					if (opt_q[OPT_EXTRA]) begin
						phase_n     = PH_XLEN;
						remaining_n = XLEN_LEN;
					end else begin
						phase_n     = after_extra(opt_q);
						remaining_n = entry_count(phase_n, remaining_q);
					end
				end
				PH_XLEN: begin
					res_n.section = SEC_XLEN;
					if (remaining_q == XLEN_LEN) begin
						low_n       = item.value;
						remaining_n = 16'd1;
					end else begin
						remaining_n = {item.value, low_q};
						if (remaining_n == 16'd0) begin
							phase_n     = after_extra(opt_q);
							remaining_n = entry_count(phase_n, remaining_n);
						end else begin
							phase_n = PH_EXTRA;
						end
					end
				end
				PH_EXTRA: begin
					res_n.section = SEC_EXTRA;
					remaining_n   = remaining_q - 16'd1;
					if (remaining_n == 16'd0) begin
						phase_n     = after_extra(opt_q);
						remaining_n = entry_count(phase_n, remaining_n);
					end
				end
				PH_NAME: begin
					res_n.section = SEC_NAME;
					if (item.value == 8'd0) begin
						phase_n     = after_name(opt_q);
						remaining_n = entry_count(phase_n, remaining_q);
					end
				end
				PH_COMMENT: begin
					res_n.section = SEC_COMMENT;
					if (item.value == 8'd0) begin
						phase_n     = opt_q[OPT_HCRC] ? PH_HCRC : PH_IDLE;
						remaining_n = entry_count(phase_n, remaining_q);
					end
				end
				PH_HCRC: begin
					res_n.section = SEC_HCRC;
					remaining_n   = remaining_q - 16'd1;
					if (remaining_n == 16'd0) begin
						phase_n = PH_IDLE;
					end
				end
				default: begin
					res_n.section = SEC_MTIME;
				end
			endcase
			if (phase_q != PH_IDLE && phase_q <= PH_HCRC) begin
				res_n.status = (phase_n == PH_IDLE) ? ST_LAST : ST_MORE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= 16'd0;
			opt_q       <= 4'd0;
			low_q       <= 8'd0;
		end else if (take) begin
			phase_q     <= phase_n;
			remaining_q <= remaining_n;
			opt_q       <= opt_n;
			low_q       <= low_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res_n;
		end
	end

	assign res.valid   = valid_s2;
	assign res.status  = res_s2.status;
	assign res.section = res_s2.section;

	`GHS_ASSERT_IMPLY(a_mtime_count, phase_q == PH_MTIME,
		remaining_q != 16'd0 && remaining_q <= MTIME_LEN, "mtime count out of range")
	`GHS_ASSERT_IMPLY(a_hcrc_count, phase_q == PH_HCRC,
		remaining_q == 16'd1 || remaining_q == HCRC_LEN, "hcrc count out of range")
	`GHS_ASSERT_IMPLY(a_extra_count, phase_q == PH_EXTRA,
		remaining_q != 16'd0, "extra section entered with no bytes left")
	`GHS_ASSERT_NEXT(a_start_result, take && item.kind == KIND_START,
		res.valid && res.status == ST_STARTED && phase_q == PH_MTIME,
		"start request did not restart the header")

endmodule

### rtl/core/gzip_header_skipper.sv
// a request accepted into the input register moves on into the result register
// throughput: one header byte per cycle, no bubbles while the result side keeps up
// the input register and the result register each hold one request, a held result stalls
// intake once both are full
// the header walk state registers update as an item leaves the input register
// reset (arst_n low) empties both registers and returns the walker to idle
module gzip_header_skipper
	import ghs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	ghs_byte_if.sink       hdr_bytes,
	ghs_tag_if.source      tags
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	ghs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr      (hdr_bytes),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ghs_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.take       (take),
		.res        (tags)
	);

endmodule

### bench/gzip_header_skipper_test.sv
`timescale 1ns / 100ps

module gzip_header_skipper_test;
	import ghs_pkg::*;

	localparam int HOLD_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n;

	ghs_byte_if byte_ch ();
	ghs_tag_if  tag_ch ();

	gzip_header_skipper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_bytes (byte_ch),
		.tags      (tag_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// header walk as the block should see it
	phase_t      hdr_phase = PH_IDLE;
	logic [15:0] left = '0;
	logic [3:0]  opts = '0;
	logic [7:0]  xlen_lo = '0;

	result_t expected_tags[$];
	result_t oldest_tag;
	int      mismatches = 0;
	int      useful_items = 0;
	logic    idling = 1'b1;
	logic    hold_tags = 1'b0;

	function automatic void enter_hcrc_or_end();
		if (opts[OPT_HCRC]) begin
			hdr_phase = PH_HCRC;
			left = HCRC_LEN;
		end else begin
			hdr_phase = PH_IDLE;
			left = '0;
		end
	endfunction

	function automatic void enter_comment_or_later();
		if (opts[OPT_COMMENT])
			hdr_phase = PH_COMMENT;
		else
			enter_hcrc_or_end();
	endfunction

	function automatic void enter_name_or_later();
		if (opts[OPT_NAME])
			hdr_phase = PH_NAME;
		else
			enter_comment_or_later();
	endfunction

	function automatic result_t walk_header(input logic k, input logic [7:0] v);
		result_t r;
		r.section = SEC_MTIME;
		r.status = ST_STARTED;
		if (k == KIND_START) begin
			opts = v[4:1];
			hdr_phase = PH_MTIME;
			left = MTIME_LEN;
			xlen_lo = '0;
			return r;
		end
		if (hdr_phase < PH_MTIME || hdr_phase > PH_HCRC) begin
			r.status = ST_IGNORED;
			return r;
		end
		r.section = 3'(hdr_phase - 1);
		case (hdr_phase)
			PH_MTIME: begin
				left = left - 16'd1;
				if (left == 16'd0)
					hdr_phase = PH_XFL;
			end
			PH_XFL: hdr_phase = PH_OS;
			PH_OS: begin
				if (opts[OPT_EXTRA]) begin
					hdr_phase = PH_XLEN;
					left = XLEN_LEN;
				end else begin
					enter_name_or_later();
				end
			end
			PH_XLEN: begin
				if (left == XLEN_LEN) begin
					xlen_lo = v;
					left = 16'd1;
				end else begin
					left = {v, xlen_lo};
					if (left == 16'd0)
						enter_name_or_later();
					else
						hdr_phase = PH_EXTRA;
				end
			end
			PH_EXTRA: begin
				left = left - 16'd1;
				if (left == 16'd0)
					enter_name_or_later();
			end
			PH_NAME: begin
				if (v == 8'h00)
					enter_comment_or_later();
			end
			PH_COMMENT: begin
				if (v == 8'h00)
					enter_hcrc_or_end();
			end
			default: begin
				left = left - 16'd1;
				if (left == 16'd0)
					hdr_phase = PH_IDLE;
			end
		endcase
		r.status = (hdr_phase == PH_IDLE) ? ST_LAST : ST_MORE;
		return r;
	endfunction

	task automatic send_request(input logic k, input logic [7:0] v);
		result_t r;
		if (idling && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.kind <= k;
		byte_ch.value <= v;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		r = walk_header(k, v);
		if (r.status != ST_IGNORED)
			useful_items++;
		expected_tags.push_back(r);
	endtask

	// cut below zero or past the end sends the whole header, otherwise only that many bytes after the start
	task automatic send_header(input logic [7:0] flg, input int xlen, input int cut);
		logic [7:0] body[$];
		int n;
		repeat (6) body.push_back(8'($urandom));
		if (flg[OPT_EXTRA + 1]) begin
			body.push_back(xlen[7:0]);
			body.push_back(xlen[15:8]);
			repeat (xlen) body.push_back(8'($urandom));
		end
		if (flg[OPT_NAME + 1]) begin
			repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(1, 255)));
			body.push_back(8'h00);
		end
		if (flg[OPT_COMMENT + 1]) begin
			repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(1, 255)));
			body.push_back(8'h00);
		end
		if (flg[OPT_HCRC + 1])
			repeat (2) body.push_back(8'($urandom));
		send_request(KIND_START, flg);
		n = (cut >= 0 && cut < body.size()) ? cut : body.size();
		for (int i = 0; i < n; i++)
			send_request(KIND_BYTE, body[i]);
	endtask

	task automatic test_idle_bytes();
		send_request(KIND_BYTE, 8'h00);
		send_request(KIND_BYTE, 8'hFF);
	endtask

	task automatic test_restart_and_plain();
		send_request(KIND_START, 8'hE1);
		send_request(KIND_BYTE, 8'h80);
		send_request(KIND_START, 8'h00);
		send_request(KIND_BYTE, 8'hFF);
		send_request(KIND_BYTE, 8'h00);
		send_request(KIND_BYTE, 8'h55);
		send_request(KIND_BYTE, 8'hAA);
		send_request(KIND_BYTE, 8'h02);
		send_request(KIND_BYTE, 8'hFF);
	endtask

	task automatic test_empty_extra();
		send_request(KIND_START, 8'h04);
		repeat (6) send_request(KIND_BYTE, 8'h01);
		send_request(KIND_BYTE, 8'h00);
		send_request(KIND_BYTE, 8'h00);
	endtask

	task automatic test_backpressure();
		hold_tags = 1'b1;
		idling = 1'b0;
		send_header(8'h1E, 3, -1);
		send_header(8'h00, 0, -1);
		idling = 1'b1;
	endtask

	task automatic test_random_headers();
		int pick;
		int xlen;
		logic [7:0] flg;
		while (useful_items < 900) begin
			pick = $urandom_range(0, 19);
			flg = 8'($urandom);
			xlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			idling = ($urandom_range(0, 3) != 0);
			if (pick < 15) begin
				send_header(flg, xlen, -1);
			end else if (pick < 17) begin
				// abandoned header, often inside a long extra field
				flg[OPT_EXTRA + 1] = 1'b1;
				if ($urandom_range(0, 1) == 0)
					xlen = $urandom_range(0, 65535);
				send_header(flg, xlen, $urandom_range(0, 12));
			end else begin
				repeat ($urandom_range(1, 4))
					send_request(1'($urandom_range(0, 1)), 8'($urandom));
			end
		end
	endtask

	task automatic test_steady_stream();
		idling = 1'b0;
		send_header(8'h1E, 2, -1);
		send_header(8'hFF, 0, -1);
		send_header(8'($urandom), 5, -1);
		send_header(8'h00, 0, -1);
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.kind = KIND_START;
		byte_ch.value = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_restart_and_plain();
		test_empty_extra();
		test_backpressure();
		test_random_headers();
		test_steady_stream();
		byte_ch.valid <= 1'b0;
		while (expected_tags.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("gzip_header_skipper_test OK");
		else
			$display("gzip_header_skipper_test NOT OK");
		$finish;
	end

	// result side, with random stalls and a long hold-off when a test asks for one
	initial begin
		tag_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tags) begin
				hold_tags = 1'b0;
				tag_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idling && $urandom_range(0, 4) == 0) begin
				tag_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			tag_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && tag_ch.valid && tag_ch.ready) begin
			if (expected_tags.size() == 0) begin
				$display("%0t: unexpected tag, status %0d section %0d", $time,
					tag_ch.status, tag_ch.section);
				mismatches++;
			end else begin
				oldest_tag = expected_tags.pop_front();
				if (tag_ch.status !== oldest_tag.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						oldest_tag.status, tag_ch.status);
					mismatches++;
				end
				if (tag_ch.section !== oldest_tag.section) begin
					$display("%0t: section expected %0d got %0d", $time,
						oldest_tag.section, tag_ch.section);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("gzip_header_skipper_test NOT OK");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ghs_pkg.sv
rtl/core/ghs_byte_if.sv
rtl/core/ghs_tag_if.sv
rtl/core/ghs_in_stage.sv
rtl/core/ghs_walker.sv
rtl/core/gzip_header_skipper.sv
bench/gzip_header_skipper_test.sv
